// File: design/ssif_pkg.sv
// Package for the SSIF response reassembler: shared types, codes and constants.
// Used by every module of the block; it depends on nothing else.
`default_nettype none
package ssif_pkg;

    localparam int BLOCK_BYTES  = 32;
    localparam int BUFFER_BYTES = 1024;

    localparam logic [7:0] CMD_START  = 8'h03;
    localparam logic [7:0] CMD_MIDDLE = 8'h09;
    localparam logic [7:0] END_MARK   = 8'hFF;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NORESP = 3'd1;
    localparam logic [2:0] ST_DEVERR = 3'd2;
    localparam logic [2:0] ST_SMALL  = 3'd3;
    localparam logic [2:0] ST_BUS    = 3'd4;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_MIDDLE = 2'd1;
    localparam logic [1:0] PH_SINGLE = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_RETRIES  = 1'b1;

    localparam logic [10:0] CAP_RESET     = 11'd1024;
    localparam logic [3:0]  RETRIES_RESET = 4'd5;

    typedef struct packed {
        logic [10:0] capacity;
        logic [3:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  data_index;
        logic        done_res;
        logic [2:0]  status;
        logic [10:0] total_length;
        logic        retry_request;
        logic [7:0]  retry_block;
        logic [7:0]  next_command;
    } t_res;

endpackage
`default_nettype wire

// File: design/ssif_cfg.sv
// Configuration registers of the SSIF reassembler behind an APB-style port.
// Depends on ssif_pkg for the register indexes, reset values and t_cfg.
`default_nettype none
module ssif_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ssif_pkg::t_cfg     o_cfg
);
    import ssif_pkg::*;

    logic [10:0] r_cap;
    logic [3:0]  r_max;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Registers sit on word boundaries; the word index is paddr[2].
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_max <= RETRIES_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_CAPACITY) begin
                r_cap <= pwdata[10:0];
            end else begin
                r_max <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_RETRIES) begin
            prdata = {28'd0, r_max};
        end else begin
            prdata = {21'd0, r_cap};
        end
    end

    assign o_cfg.capacity    = r_cap;
    assign o_cfg.max_retries = r_max;

endmodule
`default_nettype wire

// File: design/ssif_step.sv
// Per-word decision logic and transaction state of the SSIF reassembler.
// Depends on ssif_pkg; produces up to two results for each word it takes.
`default_nettype none
module ssif_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic [7:0]     i_block_len,
    input  wire logic           i_first_of_block,
    input  wire logic           i_last_of_block,
    input  wire logic           i_bus_error,
    input  wire ssif_pkg::t_cfg i_cfg,
    output logic [1:0]          o_cnt,
    output ssif_pkg::t_res      o_res0,
    output ssif_pkg::t_res      o_res1
);
    import ssif_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_exp, n_exp;
    logic [10:0] r_coll, n_coll;
    logic [4:0]  r_rc, n_rc;
    logic        r_drop, n_drop;

    logic [10:0] cap;
    logic        go_on, ends, cont, is_match;
    logic        st_a, st_b, fin, fin_end, retry;
    logic [7:0]  byte_a, byte_b;
    logic [2:0]  fin_st;
    logic [11:0] need;
    t_res        res_w;

    assign cap = (i_cfg.capacity > CAP_RESET) ? CAP_RESET : i_cfg.capacity;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_held  = r_held;
        n_exp   = r_exp;
        n_coll  = r_coll;
        n_rc    = r_rc;
        n_drop  = r_drop;
        go_on   = 1'b0;
        ends    = 1'b0;
        cont    = 1'b0;
        is_match = 1'b0;
        st_a    = 1'b0;
        st_b    = 1'b0;
        byte_a  = i_rx_byte;
        byte_b  = i_rx_byte;
        fin     = 1'b0;
        fin_end = 1'b1;
        fin_st  = ST_OK;
        retry   = 1'b0;
        need    = 12'd0;
        o_cnt   = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        res_w   = '0;

        // Decide what this word does.
        if (i_bus_error) begin
            if (r_phase == PH_SKIP) begin
                n_phase = PH_START;
                n_pos   = 6'd0;
            end else begin
                fin    = 1'b1;
                fin_st = ST_BUS;
            end
        end else begin
            go_on = 1'b1;
            if (i_first_of_block) begin
                if (r_phase != PH_MIDDLE) begin
                    n_phase = PH_START;
                    n_coll  = 11'd0;
                    n_exp   = 8'd0;
                    n_rc    = 5'd0;
                end
                n_pos  = 6'd0;
                n_drop = 1'b0;
            end else if (r_pos == 6'd0) begin
                go_on = 1'b0;
            end
            ends = i_last_of_block || (({2'b00, n_pos} + 8'd1) >= i_block_len);
            need = {1'b0, n_coll} + {4'd0, i_block_len} - 12'd1;
            if (go_on) begin
                case (n_phase)
                    PH_SKIP: begin
                        if (ends) begin
                            n_phase = PH_START;
                            n_pos   = 6'd0;
                        end else if (n_pos < 6'd63) begin
                            n_pos = n_pos + 6'd1;
                        end
                    end
                    PH_START: begin
                        if (n_pos == 6'd0) begin
                            if (i_block_len == 8'd0) begin
                                fin = 1'b1; fin_st = ST_NORESP; fin_end = ends;
                            end else if (i_block_len > 8'(BLOCK_BYTES)) begin
                                fin = 1'b1; fin_st = ST_DEVERR; fin_end = ends;
                            end else if (i_block_len != 8'(BLOCK_BYTES) || ends) begin
                                if ({3'd0, i_block_len} > cap) begin
                                    fin = 1'b1; fin_st = ST_SMALL; fin_end = ends;
                                end else begin
                                    st_a = 1'b1;
                                    if (ends) begin
                                        fin = 1'b1;
                                    end else begin
                                        n_phase = PH_SINGLE;
                                        n_pos   = 6'd1;
                                    end
                                end
                            end else begin
                                n_held = i_rx_byte;
                                n_pos  = 6'd1;
                            end
                        end else if (n_pos == 6'd1) begin
                            if (n_held == 8'd0 && i_rx_byte == 8'd1) begin
                                if (cap < 11'(BLOCK_BYTES - 2)) begin
                                    fin = 1'b1; fin_st = ST_SMALL; fin_end = ends;
                                end else if (ends) begin
                                    n_phase = PH_MIDDLE;
                                    n_pos   = 6'd0;
                                end else begin
                                    n_pos = 6'd2;
                                end
                            end else if (cap < 11'(BLOCK_BYTES)) begin
                                fin = 1'b1; fin_st = ST_SMALL; fin_end = ends;
                            end else begin
                                st_a   = 1'b1;
                                byte_a = n_held;
                                st_b   = 1'b1;
                                if (ends) begin
                                    fin = 1'b1;
                                end else begin
                                    n_phase = PH_SINGLE;
                                    n_pos   = 6'd2;
                                end
                            end
                        end else begin
                            st_a = 1'b1;
                            if (ends) begin
                                n_phase = PH_MIDDLE;
                                n_pos   = 6'd0;
                            end else if (n_pos < 6'd63) begin
                                n_pos = n_pos + 6'd1;
                            end
                        end
                    end
                    PH_SINGLE: begin
                        st_a = 1'b1;
                        if (ends) begin
                            fin = 1'b1;
                        end else if (n_pos < 6'd63) begin
                            n_pos = n_pos + 6'd1;
                        end
                    end
                    default: begin
                        // Middle and end blocks of a multi-part read.
                        if (n_pos == 6'd0) begin
                            if (i_block_len == 8'd0) begin
                                fin = 1'b1; fin_st = ST_NORESP; fin_end = ends;
                            end else if (i_block_len > 8'(BLOCK_BYTES)
                                         || i_block_len == 8'd1) begin
                                fin = 1'b1; fin_st = ST_DEVERR; fin_end = ends;
                            end else begin
                                n_held   = i_rx_byte;
                                is_match = (i_rx_byte == n_exp);
                                if (i_rx_byte == END_MARK) begin
                                    if (need > {1'b0, cap}) begin
                                        fin = 1'b1; fin_st = ST_SMALL; fin_end = ends;
                                    end else begin
                                        n_drop = 1'b0;
                                        cont   = 1'b1;
                                    end
                                end else if (is_match && need > {1'b0, cap}) begin
                                    fin = 1'b1; fin_st = ST_SMALL; fin_end = ends;
                                end else if (n_rc > {1'b0, i_cfg.max_retries}) begin
                                    fin = 1'b1; fin_st = ST_DEVERR; fin_end = ends;
                                end else begin
                                    n_drop = !is_match;
                                    cont   = 1'b1;
                                end
                            end
                        end else begin
                            st_a = !n_drop;
                            cont = 1'b1;
                        end
                        if (cont) begin
                            if (!ends) begin
                                if (n_pos < 6'd63) begin
                                    n_pos = n_pos + 6'd1;
                                end
                            end else if (n_held == END_MARK) begin
                                fin = 1'b1;
                            end else begin
                                if (n_drop) begin
                                    retry = 1'b1;
                                    if (n_rc < 5'd31) begin
                                        n_rc = n_rc + 5'd1;
                                    end
                                end else begin
                                    n_exp = n_exp + 8'd1;
                                    n_rc  = 5'd0;
                                end
                                n_drop = 1'b0;
                                n_pos  = 6'd0;
                            end
                        end
                    end
                endcase
            end
        end

        // Assemble the results in order: stores, then the end or a retry.
        if (st_a && n_coll < cap) begin
            o_res0.data_valid = 1'b1;
            o_res0.data_byte  = byte_a;
            o_res0.data_index = n_coll[9:0];
            o_cnt  = 2'd1;
            n_coll = n_coll + 11'd1;
        end
        if (st_b && n_coll < cap) begin
            res_w            = '0;
            res_w.data_valid = 1'b1;
            res_w.data_byte  = byte_b;
            res_w.data_index = n_coll[9:0];
            if (o_cnt == 2'd0) begin
                o_res0 = res_w;
            end else begin
                o_res1 = res_w;
            end
            o_cnt  = o_cnt + 2'd1;
            n_coll = n_coll + 11'd1;
        end
        if (fin) begin
            if (o_cnt == 2'd0) begin
                o_cnt = 2'd1;
            end
            if (o_cnt == 2'd2) begin
                o_res1.done_res     = 1'b1;
                o_res1.status       = fin_st;
                o_res1.total_length = (fin_st == ST_SMALL) ? 11'd0 : n_coll;
            end else begin
                o_res0.done_res     = 1'b1;
                o_res0.status       = fin_st;
                o_res0.total_length = (fin_st == ST_SMALL) ? 11'd0 : n_coll;
            end
            n_coll = 11'd0;
            n_exp  = 8'd0;
            n_rc   = 5'd0;
            n_drop = 1'b0;
            n_held = 8'd0;
            if (fin_end) begin
                n_phase = PH_START;
                n_pos   = 6'd0;
            end else begin
                n_phase = PH_SKIP;
                if (n_pos < 6'd63) begin
                    n_pos = n_pos + 6'd1;
                end
            end
        end
        if (retry) begin
            res_w               = '0;
            res_w.retry_request = 1'b1;
            res_w.retry_block   = n_exp;
            if (o_cnt == 2'd0) begin
                o_res0 = res_w;
            end else begin
                o_res1 = res_w;
            end
            o_cnt = o_cnt + 2'd1;
        end
        o_res0.next_command = (n_phase == PH_MIDDLE) ? CMD_MIDDLE : CMD_START;
        o_res1.next_command = (n_phase == PH_MIDDLE) ? CMD_MIDDLE : CMD_START;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_pos   <= 6'd0;
            r_held  <= 8'd0;
            r_exp   <= 8'd0;
            r_coll  <= 11'd0;
            r_rc    <= 5'd0;
            r_drop  <= 1'b0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_exp   <= n_exp;
            r_coll  <= n_coll;
            r_rc    <= n_rc;
            r_drop  <= n_drop;
        end
    end

endmodule
`default_nettype wire

// File: design/ssif_rfifo.sv
// Four-entry result queue of the SSIF reassembler, taking up to two results a cycle.
// Depends on ssif_pkg for t_res.
`default_nettype none
module ssif_rfifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_push_cnt,
    input  wire ssif_pkg::t_res i_res0,
    input  wire ssif_pkg::t_res i_res1,
    input  wire logic           i_pop,
    output logic                o_room2,
    output logic                o_valid,
    output ssif_pkg::t_res      o_head
);
    import ssif_pkg::*;

    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;
    logic       do_pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'd2);
    assign do_pop  = i_pop && o_valid;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp    <= r_wp + i_push_cnt;
            r_rp    <= r_rp + {1'b0, do_pop};
            r_count <= r_count + {1'b0, i_push_cnt} - {2'b00, do_pop};
        end
    end

endmodule
`default_nettype wire

// File: design/ssif_response_reassembler_core.sv
// Top level of the host-side IPMI SSIF response reassembler.
// Depends on ssif_pkg, ssif_cfg, ssif_step and ssif_rfifo.
//
// Usage: the SMBus side delivers one received word per handshake on the input
// channel (i_in_valid / o_in_ready) with the byte, the block's reported length
// and first/last/bus-error flags. The block strips block headers, tells a
// single-part read from a multi-part read, and emits results on the output
// channel (o_out_valid / i_out_ready): payload bytes with buffer index, retry
// requests for mismatched middle blocks, and a final word carrying done and
// status. One input word makes zero, one or two results.
// Flow: a word is captured in the input register, decided by the step logic once
// the result queue has room, and its results are written into that queue, whose
// head drives the output channel. Throughput is one word per cycle while the
// queue has room; the four-entry result queue must have room for two results
// before a captured word is processed.
// Reset (i_rst_n low, synchronous) restores the capacity to 1024 bytes, the
// retry limit to 5, empties the queue and expects a start block.
// When the receiver stalls, results wait in the queue; once it holds more than
// two entries the input register stops draining and o_in_ready drops.
// Configuration is written over the APB-style port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
`default_nettype none
module ssif_response_reassembler_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_block_len,
    input  wire logic        i_first_of_block,
    input  wire logic        i_last_of_block,
    input  wire logic        i_bus_error,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_data_valid,
    output logic [7:0]       o_data_byte,
    output logic [9:0]       o_data_index,
    output logic             o_done_res,
    output logic [2:0]       o_status,
    output logic [10:0]      o_total_length,
    output logic             o_retry_request,
    output logic [7:0]       o_retry_block,
    output logic [7:0]       o_next_command,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ssif_pkg::*;

    // Input register: holds one accepted word until the step logic takes it.
    logic       r_in_valid;
    logic [7:0] r_rx_byte;
    logic [7:0] r_block_len;
    logic       r_first;
    logic       r_last;
    logic       r_berr;

    t_cfg       cfg;
    logic       step_go;
    logic       room2;
    logic [1:0] push_cnt;
    logic [1:0] step_cnt;
    t_res       res0, res1, head;

    ssif_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The captured word is processed only when the queue can absorb two results.
    assign step_go    = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || step_go;
    assign push_cnt   = step_go ? step_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_rx_byte   <= i_rx_byte;
            r_block_len <= i_block_len;
            r_first     <= i_first_of_block;
            r_last      <= i_last_of_block;
            r_berr      <= i_bus_error;
        end
    end

    ssif_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (step_go),
        .i_rx_byte        (r_rx_byte),
        .i_block_len      (r_block_len),
        .i_first_of_block (r_first),
        .i_last_of_block  (r_last),
        .i_bus_error      (r_berr),
        .i_cfg            (cfg),
        .o_cnt            (step_cnt),
        .o_res0           (res0),
        .o_res1           (res1)
    );

    ssif_rfifo u_rfifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (i_out_ready),
        .o_room2    (room2),
        .o_valid    (o_out_valid),
        .o_head     (head)
    );

    assign o_data_valid    = head.data_valid;
    assign o_data_byte     = head.data_byte;
    assign o_data_index    = head.data_index;
    assign o_done_res      = head.done_res;
    assign o_status        = head.status;
    assign o_total_length  = head.total_length;
    assign o_retry_request = head.retry_request;
    assign o_retry_block   = head.retry_block;
    assign o_next_command  = head.next_command;

endmodule
`default_nettype wire

// File: dv/ssif_response_reassembler_core_test.sv
// Self-checking testbench for ssif_response_reassembler_core: random and directed SMBus words
// are checked against a cycle-free model of the reassembler, over several register settings.
// Depends on ssif_pkg and the RTL of the block; it needs no other file.
module ssif_response_reassembler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssif_pkg::*;

    // The run is cut off here; a clean run needs a small fraction of this.
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles after the last result before the registers change or the run ends.
    localparam int DRAIN_CYCLES = 8;

    // One word on the input channel, as the SMBus controller hands it over.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] block_len;
        logic       first_of_block;
        logic       last_of_block;
        logic       bus_error;
    } t_smbus_word;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    t_smbus_word drv_word = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    t_res        got;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Words waiting to be driven, words being built by a generator, and the results
    // that the reassembly model says the block still owes.
    t_smbus_word smbus_words[$];
    t_smbus_word draft[$];
    t_res        reassembly_out_q[$];
    t_res        step_out[$];

    int          send_idle = 0;
    int          recv_idle = 0;
    int          n_errors = 0;
    int          cycles = 0;

    // Register copies and state of the reassembly model.
    logic [10:0] cap_reg = CAP_RESET;
    logic [3:0]  retry_limit = RETRIES_RESET;
    logic [1:0]  asm_phase = PH_START;
    logic [5:0]  asm_pos = '0;
    logic [7:0]  asm_head = '0;
    logic [7:0]  asm_block_no = '0;
    logic [10:0] asm_count = '0;
    logic [4:0]  asm_retries = '0;
    logic        asm_discard = 1'b0;

    ssif_response_reassembler_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (drv_word.rx_byte),
        .i_block_len      (drv_word.block_len),
        .i_first_of_block (drv_word.first_of_block),
        .i_last_of_block  (drv_word.last_of_block),
        .i_bus_error      (drv_word.bus_error),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_data_valid     (got.data_valid),
        .o_data_byte      (got.data_byte),
        .o_data_index     (got.data_index),
        .o_done_res       (got.done_res),
        .o_status         (got.status),
        .o_total_length   (got.total_length),
        .o_retry_request  (got.retry_request),
        .o_retry_block    (got.retry_block),
        .o_next_command   (got.next_command),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Reassembly model
    // ------------------------------------------------------------------

    // Capacities above the physical buffer behave like the physical buffer.
    function automatic int buf_limit();
        return (int'(cap_reg) > BUFFER_BYTES) ? BUFFER_BYTES : int'(cap_reg);
    endfunction

    // The byte position saturates; only positions 0 and 1 matter once past the header.
    function automatic void bump_pos();
        if (asm_pos < 6'd63) asm_pos = asm_pos + 6'd1;
    endfunction

    // A payload byte is only delivered while the buffer has room for it.
    function automatic void emit_byte(logic [7:0] b);
        t_res r;
        if (int'(asm_count) < buf_limit()) begin
            r = '0;
            r.data_valid = 1'b1;
            r.data_byte = b;
            r.data_index = asm_count[9:0];
            step_out.push_back(r);
            asm_count = asm_count + 11'd1;
        end
    endfunction

    // Ends the transaction. The done flag rides on the last data result of the word
    // if there is one. When the block is not yet over, the rest of it is skipped.
    function automatic void close_txn(logic [2:0] st, bit at_end);
        t_res r;
        if (step_out.size() != 0) r = step_out.pop_back();
        else r = '0;
        r.done_res = 1'b1;
        r.status = st;
        r.total_length = (st == ST_SMALL) ? 11'd0 : asm_count;
        step_out.push_back(r);
        asm_count = '0;
        asm_block_no = '0;
        asm_retries = '0;
        asm_discard = 1'b0;
        asm_head = '0;
        if (at_end) begin
            asm_phase = PH_START;
            asm_pos = '0;
        end else begin
            asm_phase = PH_SKIP;
            bump_pos();
        end
    endfunction

    // First block of a response: decides between single-part and multi-part reads.
    function automatic void start_block(logic [7:0] b, int len, bit at_end);
        int lim;
        lim = buf_limit();
        if (asm_pos == 6'd0) begin
            if (len == 0) begin
                close_txn(ST_NORESP, at_end);
                return;
            end
            if (len > BLOCK_BYTES) begin
                close_txn(ST_DEVERR, at_end);
                return;
            end
            if (len != BLOCK_BYTES || at_end) begin
                if (len > lim) begin
                    close_txn(ST_SMALL, at_end);
                    return;
                end
                emit_byte(b);
                if (at_end) close_txn(ST_OK, 1'b1);
                else begin
                    asm_phase = PH_SINGLE;
                    bump_pos();
                end
                return;
            end
            // A full-size block may still be a multi-part start: hold the byte.
            asm_head = b;
            bump_pos();
            return;
        end
        if (asm_pos == 6'd1) begin
            if (asm_head == 8'h00 && b == 8'h01) begin
                if (BLOCK_BYTES - 2 > lim) begin
                    close_txn(ST_SMALL, at_end);
                    return;
                end
                if (at_end) begin
                    asm_phase = PH_MIDDLE;
                    asm_pos = '0;
                end else begin
                    bump_pos();
                end
                return;
            end
            if (BLOCK_BYTES > lim) begin
                close_txn(ST_SMALL, at_end);
                return;
            end
            emit_byte(asm_head);
            emit_byte(b);
            if (at_end) close_txn(ST_OK, 1'b1);
            else begin
                asm_phase = PH_SINGLE;
                bump_pos();
            end
            return;
        end
        emit_byte(b);
        if (at_end) begin
            asm_phase = PH_MIDDLE;
            asm_pos = '0;
        end else begin
            bump_pos();
        end
    endfunction

    // Middle or end block of a multi-part read; the first byte is the block number.
    function automatic void middle_block(logic [7:0] b, int len, bit at_end);
        int   need;
        bit   hit;
        t_res r;
        need = int'(asm_count) + len - 1;
        if (asm_pos == 6'd0) begin
            if (len == 0) begin
                close_txn(ST_NORESP, at_end);
                return;
            end
            if (len > BLOCK_BYTES || len == 1) begin
                close_txn(ST_DEVERR, at_end);
                return;
            end
            asm_head = b;
            if (b == END_MARK) begin
                if (need > buf_limit()) begin
                    close_txn(ST_SMALL, at_end);
                    return;
                end
                asm_discard = 1'b0;
            end else begin
                hit = (b == asm_block_no);
                if (hit && need > buf_limit()) begin
                    close_txn(ST_SMALL, at_end);
                    return;
                end
                if (int'(asm_retries) > int'(retry_limit)) begin
                    close_txn(ST_DEVERR, at_end);
                    return;
                end
                asm_discard = !hit;
            end
        end else if (!asm_discard) begin
            emit_byte(b);
        end
        if (!at_end) begin
            bump_pos();
            return;
        end
        if (asm_head == END_MARK) begin
            close_txn(ST_OK, 1'b1);
            return;
        end
        if (asm_discard) begin
            // A block with the wrong number is thrown away and asked for again.
            r = '0;
            r.retry_request = 1'b1;
            r.retry_block = asm_block_no;
            step_out.push_back(r);
            if (asm_retries < 5'd31) asm_retries = asm_retries + 5'd1;
        end else begin
            asm_block_no = asm_block_no + 8'd1;
            asm_retries = '0;
        end
        asm_discard = 1'b0;
        asm_pos = '0;
    endfunction

    // Runs one accepted word through the model and queues the results it owes.
    function automatic void reassemble_word(t_smbus_word w);
        bit   at_end;
        int   len;
        t_res r;
        step_out.delete();
        len = int'(w.block_len);
        if (w.bus_error) begin
            // While skipping, a bus error only ends the skip.
            if (asm_phase == PH_SKIP) begin
                asm_phase = PH_START;
                asm_pos = '0;
                return;
            end
            close_txn(ST_BUS, 1'b1);
        end else begin
            if (w.first_of_block) begin
                // A new block restarts everything except a multi-part read in progress.
                if (asm_phase != PH_MIDDLE) begin
                    asm_phase = PH_START;
                    asm_count = '0;
                    asm_block_no = '0;
                    asm_retries = '0;
                end
                asm_pos = '0;
                asm_discard = 1'b0;
            end else if (asm_pos == 6'd0) begin
                // Stray byte outside any open block.
                return;
            end
            at_end = w.last_of_block || (int'(asm_pos) + 1 >= len);
            case (asm_phase)
                PH_SKIP: begin
                    if (at_end) begin
                        asm_phase = PH_START;
                        asm_pos = '0;
                    end else begin
                        bump_pos();
                    end
                    return;
                end
                PH_START: start_block(w.rx_byte, len, at_end);
                PH_SINGLE: begin
                    emit_byte(w.rx_byte);
                    if (at_end) close_txn(ST_OK, 1'b1);
                    else bump_pos();
                end
                default: middle_block(w.rx_byte, len, at_end);
            endcase
        end
        foreach (step_out[k]) begin
            r = step_out[k];
            r.next_command = (asm_phase == PH_MIDDLE) ? CMD_MIDDLE : CMD_START;
            reassembly_out_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Word builders. They append to the draft, which the stimulus process moves
    // into the driver's queue as a whole.
    // ------------------------------------------------------------------

    function automatic void add_word(logic [7:0] b, logic [7:0] len, bit f, bit l, bit e);
        t_smbus_word w;
        w.rx_byte = b;
        w.block_len = len;
        w.first_of_block = f;
        w.last_of_block = l;
        w.bus_error = e;
        draft.push_back(w);
    endfunction

    // Puts cnt bytes of a block of reported length len. A negative header value means a
    // random byte. A block cut short by the last flag always carries it; a full block
    // only sometimes, since its length alone ends it.
    function automatic void put_block(int len, int cnt, int head0, int head1);
        t_smbus_word w;
        for (int i = 0; i < cnt; i++) begin
            w.rx_byte = 8'($urandom);
            if (i == 0 && head0 >= 0) w.rx_byte = head0[7:0];
            if (i == 1 && head1 >= 0) w.rx_byte = head1[7:0];
            w.block_len = len[7:0];
            w.first_of_block = (i == 0);
            w.last_of_block = (i == cnt - 1) && (cnt < len || $urandom_range(0, 3) != 0);
            w.bus_error = 1'b0;
            draft.push_back(w);
        end
    endfunction

    // A bus error always brings the block back to waiting for a start block.
    function automatic void resync();
        add_word(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
    endfunction

    function automatic void gen_single();
        int len;
        len = ($urandom_range(0, 9) == 0) ? BLOCK_BYTES : $urandom_range(1, BLOCK_BYTES - 1);
        put_block(len, len, -1, -1);
    endfunction

    // A well-formed multi-part read with random payload, now and then with blocks
    // carrying the wrong number and, rarely, long enough to fill the buffer.
    function automatic void gen_multi();
        int blocks;
        int tries;
        int len;
        int wrong;
        if ($urandom_range(0, 7) == 0) put_block(BLOCK_BYTES, $urandom_range(2, 31), 0, 1);
        else put_block(BLOCK_BYTES, BLOCK_BYTES, 0, 1);
        blocks = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 36) : $urandom_range(0, 3);
        for (int no = 0; no < blocks; no++) begin
            if ($urandom_range(0, 7) == 0) begin
                tries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 1;
                repeat (tries) begin
                    // Any number but the expected one and the end mark.
                    wrong = (no + $urandom_range(1, 254)) % 255;
                    len = $urandom_range(2, BLOCK_BYTES);
                    put_block(len, len, wrong, -1);
                end
            end
            len = $urandom_range(2, BLOCK_BYTES);
            put_block(len, len, no, -1);
        end
        len = $urandom_range(2, BLOCK_BYTES);
        put_block(len, len, END_MARK, -1);
    endfunction

    // A read that may be cut short and has one word damaged, followed by a bus error.
    function automatic void gen_broken();
        int          keep;
        int          idx;
        t_smbus_word w;
        if ($urandom_range(0, 1) != 0) gen_multi();
        else gen_single();
        keep = $urandom_range(1, draft.size());
        while (draft.size() > keep) void'(draft.pop_back());
        idx = $urandom_range(0, draft.size() - 1);
        w = draft[idx];
        case ($urandom_range(0, 4))
            0: w.block_len = 8'($urandom);
            1: w.block_len = 8'd0;
            2: w.block_len = 8'd1;
            3: w.first_of_block = !w.first_of_block;
            default: w.bus_error = 1'b1;
        endcase
        draft[idx] = w;
        resync();
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(1, 8)) begin
            add_word(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                     $urandom_range(0, 7) == 0);
        end
        resync();
    endfunction

    function automatic int flush();
        int n;
        n = draft.size();
        foreach (draft[k]) smbus_words.push_back(draft[k]);
        draft.delete();
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents words from the queue and runs the model on each word at the
    // edge where it is accepted. A word stays on the port until it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) reassemble_word(drv_word);
            if (!in_valid || in_ready) begin
                if (smbus_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    drv_word <= smbus_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result taken from the block is compared with the oldest one
    // the model owes.
    // ------------------------------------------------------------------
    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            n_errors++;
            $error("%s: expected %0d, got %0d", name, want, seen);
        end
    endfunction

    function automatic void check_result();
        t_res want;
        if (reassembly_out_q.size() == 0) begin
            n_errors++;
            $error("result with nothing owed: data_valid %0d byte %0d done %0d status %0d",
                   got.data_valid, got.data_byte, got.done_res, got.status);
            return;
        end
        want = reassembly_out_q.pop_front();
        cmp_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
        cmp_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
        cmp_field("data_index", 32'(want.data_index), 32'(got.data_index));
        cmp_field("done_res", 32'(want.done_res), 32'(got.done_res));
        cmp_field("status", 32'(want.status), 32'(got.status));
        cmp_field("total_length", 32'(want.total_length), 32'(got.total_length));
        cmp_field("retry_request", 32'(want.retry_request), 32'(got.retry_request));
        cmp_field("retry_block", 32'(want.retry_block), 32'(got.retry_block));
        cmp_field("next_command", 32'(want.next_command), 32'(got.next_command));
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) check_result();
            out_ready <= $urandom_range(0, 99) >= recv_idle;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port access. Each transfer has a setup and an access cycle; the
    // transfer completes at the edge where the access cycle sees pready.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_regs();
        logic [31:0] rd;
        apb_read({REG_CAPACITY, 2'b00}, rd);
        cmp_field("response_capacity", 32'(cap_reg), 32'(rd[10:0]));
        apb_read({REG_RETRIES, 2'b00}, rd);
        cmp_field("max_retries", 32'(retry_limit), 32'(rd[3:0]));
    endtask

    // Waits until every word has been taken and every owed result has come, then keeps
    // the clock running for words that make no result but may still be in flight.
    task automatic settle();
        while (smbus_words.size() != 0 || in_valid || reassembly_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers change only when the block has nothing left to do. The unused upper
    // bits of the write data carry random values.
    task automatic program_regs(input logic [10:0] cap, input logic [3:0] tries);
        logic [31:0] wd;
        settle();
        wd = $urandom;
        wd[10:0] = cap;
        apb_write({REG_CAPACITY, 2'b00}, wd);
        cap_reg = cap;
        wd = $urandom;
        wd[3:0] = tries;
        apb_write({REG_RETRIES, 2'b00}, wd);
        retry_limit = tries;
        check_regs();
    endtask

    // Random part of one register setting. Each phase opens with a bus error so that
    // the first read starts from a clean state whatever the previous phase left.
    task automatic run_phase(input int words, input int s_idle, input int r_idle);
        int made;
        int pick;
        send_idle = s_idle;
        recv_idle = r_idle;
        resync();
        made = flush();
        while (made < words) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) gen_single();
            else if (pick < 75) gen_multi();
            else if (pick < 90) gen_broken();
            else gen_noise();
            made += flush();
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        check_regs();

        send_idle = 19;
        recv_idle = 56;
        // Empty block: no response.
        add_word(8'h00, 8'd0, 1'b1, 1'b0, 1'b0);
        // Oversize block: device error, then the rest of that block is skipped.
        add_word(8'hFF, 8'd255, 1'b1, 1'b0, 1'b0);
        add_word(8'h5A, 8'd255, 1'b0, 1'b1, 1'b0);
        // One-byte single-part response.
        add_word(8'hFF, 8'd1, 1'b1, 1'b1, 1'b0);
        // Stray byte with no open block is ignored.
        add_word(8'hA5, 8'd7, 1'b0, 1'b0, 1'b0);
        // Short block starting with the start pattern is still a single-part response.
        add_word(8'h00, 8'd3, 1'b1, 1'b0, 1'b0);
        add_word(8'h01, 8'd3, 1'b0, 1'b0, 1'b0);
        add_word(8'h80, 8'd3, 1'b0, 1'b1, 1'b0);
        // Multi-part start block that ends after its pattern: no result at all.
        add_word(8'h00, 8'd32, 1'b1, 1'b0, 1'b0);
        add_word(8'h01, 8'd32, 1'b0, 1'b1, 1'b0);
        // Middle block with the wrong number: dropped, retry of block zero.
        add_word(8'h05, 8'd2, 1'b1, 1'b0, 1'b0);
        add_word(8'h77, 8'd2, 1'b0, 1'b1, 1'b0);
        // Middle block of length one: device error.
        add_word(8'h00, 8'd1, 1'b1, 1'b1, 1'b0);
        // Bus error while waiting for a start block.
        add_word(8'hC3, 8'd200, 1'b0, 1'b0, 1'b1);
        // A new block arriving in the middle of a single-part block restarts the read.
        add_word(8'h11, 8'd5, 1'b1, 1'b0, 1'b0);
        add_word(8'h22, 8'd5, 1'b0, 1'b0, 1'b0);
        add_word(8'h33, 8'd2, 1'b1, 1'b0, 1'b0);
        add_word(8'h44, 8'd2, 1'b0, 1'b0, 1'b0);
        // Complete multi-part read: start, block zero, end block.
        add_word(8'h00, 8'd32, 1'b1, 1'b0, 1'b0);
        add_word(8'h01, 8'd32, 1'b0, 1'b1, 1'b0);
        add_word(8'h00, 8'd3, 1'b1, 1'b0, 1'b0);
        add_word(8'hFE, 8'd3, 1'b0, 1'b0, 1'b0);
        add_word(8'h01, 8'd3, 1'b0, 1'b1, 1'b0);
        add_word(8'hFF, 8'd2, 1'b1, 1'b0, 1'b0);
        add_word(8'h7F, 8'd2, 1'b0, 1'b1, 1'b0);
        void'(flush());
        settle();

        // Reset settings, then a one-byte buffer with no retries allowed, with the
        // receiver stalling more than the sender idles.
        run_phase(330, 19, 56);
        program_regs(11'd1, 4'd0);
        run_phase(300, 19, 56);
        // All-ones capacity is clipped to the buffer; most retries allowed.
        program_regs(11'h7FF, 4'd15);
        run_phase(300, 56, 19);
        // Zero capacity rejects every non-empty block.
        program_regs(11'd0, 4'd3);
        run_phase(250, 56, 19);
        // A mid-sized buffer that multi-part reads overflow quickly, no idling.
        program_regs(11'($urandom_range(20, 100)), 4'($urandom_range(1, 14)));
        run_phase(300, 0, 0);
        program_regs(11'd1024, 4'd5);
        run_phase(520, 0, 0);

        settle();
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: ssif_response_reassembler_core.f
design/ssif_pkg.sv
design/ssif_cfg.sv
design/ssif_step.sv
design/ssif_rfifo.sv
design/ssif_response_reassembler_core.sv
dv/ssif_response_reassembler_core_test.sv
